>>> hw/rtl/tdpc_pkg.sv
package tdpc_pkg;

  localparam int VALUE_BITS   = 31;
  localparam int COUNT_BITS   = 16;
  localparam int DIV_BITS     = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS      = VALUE_BITS + 2;
  localparam int BIT_IDX_BITS = $clog2(VALUE_BITS);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  restart;
  } tdpc_in_t;

  typedef struct packed {
    logic                  is_prime;
    logic [COUNT_BITS-1:0] prime_count;
  } tdpc_out_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic rem_start;
    logic rem_step;
    logic div_next;
    logic set_verdict;
    logic verdict;
    logic commit;
  } tdpc_cmd_t;

  typedef struct packed {
    logic trivial;
    logic trivial_prime;
    logic sq_over;
    logic bit_last;
    logic rem_zero;
    logic out_busy;
  } tdpc_sts_t;

endpackage

>>> hw/rtl/tdpc_dp.sv
module tdpc_dp
  import tdpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  tdpc_in_t   in_data,
  input  tdpc_cmd_t  cmd,
  output tdpc_sts_t  sts,
  output logic       out_valid,
  input  logic       out_stall,
  output tdpc_out_t  out_data
);

  logic [VALUE_BITS-1:0]   value_r;
  logic                    restart_r;
  logic [DIV_BITS-1:0]     d_r;
  logic [SQ_BITS-1:0]      sq_r;
  logic [DIV_BITS-1:0]     rem_r;
  logic [BIT_IDX_BITS-1:0] bit_r;
  logic                    verdict_r;
  logic [COUNT_BITS-1:0]   tally_r;
  logic                    out_valid_r;
  tdpc_out_t               out_data_r;

  logic [DIV_BITS:0]       shifted;
  logic [DIV_BITS:0]       diff;
  logic                    ge;
  logic [DIV_BITS-1:0]     rem_nxt;
  logic [COUNT_BITS-1:0]   base;
  logic [COUNT_BITS-1:0]   tally_nxt;
  logic [SQ_BITS-1:0]      sq_nxt;

  assign shifted = {rem_r, value_r[bit_r]};
  assign diff    = shifted - {1'b0, d_r};
  assign ge      = shifted >= {1'b0, d_r};
  assign rem_nxt = ge ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];

  assign sq_nxt = sq_r + (SQ_BITS'(d_r) << 2) + SQ_BITS'(4);

  assign base      = restart_r ? '0 : tally_r;
  assign tally_nxt = base + COUNT_BITS'(verdict_r && !(&base));

  assign sts.trivial       = ((value_r >> 2) == '0) || !value_r[0];
  assign sts.trivial_prime = (value_r >> 1) == VALUE_BITS'(1);
  assign sts.sq_over       = SQ_BITS'(value_r) < sq_r;
  assign sts.bit_last      = bit_r == '0;
  assign sts.rem_zero      = rem_r == '0;
  assign sts.out_busy      = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r   <= in_data.value;
      restart_r <= in_data.restart;
    end
    if (cmd.div_init) begin
      d_r  <= DIV_BITS'(3);
      sq_r <= SQ_BITS'(9);
    end else if (cmd.div_next) begin
      d_r  <= d_r + DIV_BITS'(2);
      sq_r <= sq_nxt;
    end
    if (cmd.rem_start) begin
      rem_r <= '0;
      bit_r <= BIT_IDX_BITS'(VALUE_BITS - 1);
    end else if (cmd.rem_step) begin
      rem_r <= rem_nxt;
      bit_r <= bit_r - BIT_IDX_BITS'(1);
    end
    if (cmd.set_verdict) begin
      verdict_r <= cmd.verdict;
    end
    if (cmd.commit) begin
      out_data_r.is_prime    <= verdict_r;
      out_data_r.prime_count <= tally_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        tally_r     <= tally_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/tdpc_ctrl.sv
module tdpc_ctrl
  import tdpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tdpc_sts_t  sts,
  output tdpc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_TEST,
    S_DIV,
    S_CHECK,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASS;
        end
      end
      S_CLASS: begin
        if (sts.trivial) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = sts.trivial_prime;
          state_nxt       = S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_TEST;
        end
      end
      S_TEST: begin
        if (sts.sq_over) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
          state_nxt       = S_FIN;
        end else begin
          cmd.rem_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.rem_step = 1'b1;
        if (sts.bit_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.rem_zero) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
          state_nxt       = S_FIN;
        end else begin
          cmd.div_next = 1'b1;
          state_nxt    = S_TEST;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/trial_division_prime_counter_core.sv
// Values below 4 and even values are settled in the classify state alone.
// Odd values from 5 up try odd divisors from 3 until one divides or its square
// exceeds the value (a prime takes up to 23169 divisors); each divisor
// costs one bound check, 31 restoring-remainder steps and one zero test.
// One item at a time: the next is taken the cycle after commit; a stalled result holds it.
// Reset: synchronous active-low rst_n clears the controller, output valid and prime count.
module trial_division_prime_counter_core
  import tdpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tdpc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tdpc_out_t out_data
);

  tdpc_cmd_t cmd;
  tdpc_sts_t sts;

  tdpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdpc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/tdpc_checker.sv
module tdpc_checker
  import tdpc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input tdpc_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input tdpc_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous item in work");

  a_prime_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_prime && (out_data.prime_count == '0)))
    else $error("prime result with zero count");

endmodule

bind trial_division_prime_counter_core tdpc_checker u_tdpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tdpc_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int IDLE_PCT     = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 300;
  localparam int CALM_FIRST   = 600;
  localparam int CALM_LAST    = 900;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  restart;
    logic [16:0]           reps;
    logic                  typed;
    tdpc_out_t             want;
  } probe_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  tdpc_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  tdpc_out_t out_data;

  probe_row_t            probe_rows[$];
  tdpc_out_t             verdict_q[$];
  logic [COUNT_BITS-1:0] count_model;
  int                    errors;
  bit                    calm;
  bit                    hold_req;
  int                    hold_left;

  trial_division_prime_counter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(500_000_000);
    $display("tb: errors");
    $finish;
  end

  function automatic bit value_is_prime(input logic [VALUE_BITS-1:0] v);
    longint unsigned n;
    longint unsigned d;
    n = v;
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic tdpc_out_t tally_verdict(input tdpc_in_t item);
    tdpc_out_t res;
    res.is_prime = value_is_prime(item.value);
    if (item.restart) count_model = '0;
    if (res.is_prime && count_model != '1) count_model = count_model + 1'b1;
    res.prime_count = count_model;
    return res;
  endfunction

  function automatic tdpc_in_t random_item();
    tdpc_in_t    item;
    int unsigned pick;
    int unsigned raw;
    pick = $urandom_range(99);
    if (pick < 60) begin
      raw = $urandom_range(255);
    end else if (pick < 85) begin
      raw = $urandom_range(16383);
    end else begin
      // keep wide values divisible by three so the divisor search ends at once
      raw = $urandom & 32'h7FFF_FFFF;
      raw = raw - raw % 3;
    end
    item.value   = raw[VALUE_BITS-1:0];
    item.restart = ($urandom_range(99) < 5);
    return item;
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic add_probe(input logic [VALUE_BITS-1:0] value, input logic restart,
                           input int reps, input logic typed, input logic is_prime,
                           input logic [COUNT_BITS-1:0] prime_count);
    probe_row_t row;
    row.value            = value;
    row.restart          = restart;
    row.reps             = 17'(reps);
    row.typed            = typed;
    row.want.is_prime    = is_prime;
    row.want.prime_count = prime_count;
    probe_rows.push_back(row);
  endtask

  task automatic build_probes();
    add_probe(31'd0,          1'b0, 1,     1'b1, 1'b0, 16'd0);
    add_probe(31'd1,          1'b0, 1,     1'b1, 1'b0, 16'd0);
    add_probe(31'd2,          1'b0, 1,     1'b1, 1'b1, 16'd1);
    add_probe(31'd3,          1'b0, 1,     1'b1, 1'b1, 16'd2);
    add_probe(31'd4,          1'b0, 1,     1'b1, 1'b0, 16'd2);
    add_probe(31'd5,          1'b0, 1,     1'b0, 1'b0, 16'd0);
    add_probe(31'd9,          1'b0, 1,     1'b0, 1'b0, 16'd0);
    add_probe(31'd25,         1'b0, 1,     1'b0, 1'b0, 16'd0);
    add_probe(31'd49,         1'b0, 1,     1'b0, 1'b0, 16'd0);
    add_probe(31'h7FFF_FFFF,  1'b0, 1,     1'b1, 1'b1, 16'd4);
    add_probe(31'h7FFF_FFFE,  1'b0, 1,     1'b1, 1'b0, 16'd4);
    add_probe(31'h5555_5555,  1'b0, 1,     1'b0, 1'b0, 16'd0);
    add_probe(31'h2AAA_AAAA,  1'b0, 1,     1'b0, 1'b0, 16'd0);
    add_probe(31'd7,          1'b1, 1,     1'b1, 1'b1, 16'd1);
    add_probe(31'd8,          1'b1, 1,     1'b1, 1'b0, 16'd0);
    add_probe(31'd11,         1'b0, 1,     1'b0, 1'b0, 16'd0);
    // advance the count with a run of primes
    add_probe(31'd2,          1'b0, 20,    1'b0, 1'b0, 16'd0);
    add_probe(31'd3,          1'b0, 1,     1'b0, 1'b0, 16'd0);
    add_probe(31'd15,         1'b0, 1,     1'b0, 1'b0, 16'd0);
    add_probe(31'd13,         1'b1, 1,     1'b1, 1'b1, 16'd1);
  endtask

  task automatic drive_item(input tdpc_in_t item, input bit typed, input tdpc_out_t want);
    tdpc_out_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = tally_verdict(item);
    verdict_q.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    tdpc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("unexpected item is_prime=%0b prime_count=%0d",
                             out_data.is_prime, out_data.prime_count));
      end else begin
        want = verdict_q.pop_front();
        if (out_data.is_prime !== want.is_prime)
          flag_error($sformatf("is_prime got %0b want %0b",
                               out_data.is_prime, want.is_prime));
        if (out_data.prime_count !== want.prime_count)
          flag_error($sformatf("prime_count got %0d want %0d",
                               out_data.prime_count, want.prime_count));
      end
    end
  end

  initial begin
    probe_row_t row;
    tdpc_in_t   item;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    errors      = 0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    count_model = '0;
    build_probes();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (probe_rows[i]) begin
      row          = probe_rows[i];
      item.value   = row.value;
      item.restart = row.restart;
      repeat (row.reps) drive_item(item, row.typed, row.want);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST && n < CALM_LAST);
      if (n == HOLD_AT) hold_req = 1'b1;
      drive_item(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tdpc_pkg.sv
hw/rtl/tdpc_dp.sv
hw/rtl/tdpc_ctrl.sv
hw/rtl/trial_division_prime_counter_core.sv
hw/rtl/tdpc_checker.sv
tb/sv/tb.sv
